// File: hw/rtl/spd_pkg.sv
package spd_pkg;

  localparam int NODES       = 512;
  localparam int EDGES       = 8192;
  localparam int WEIGHT_BITS = 24;
  localparam int NODE_W      = $clog2(NODES);
  localparam int EDGE_W      = $clog2(EDGES);
  localparam int DIST_W      = 32;
  localparam int EDGE_REC_W  = EDGE_W + NODE_W + WEIGHT_BITS;

  localparam logic [DIST_W-1:0] DIST_INF = '1;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_SRC    = 3'd1;
  localparam logic [2:0] OP_TGT    = 3'd2;
  localparam logic [2:0] OP_RUN    = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  typedef struct packed {
    logic [2:0]             operation;
    logic [NODE_W-1:0]      from_node;
    logic [NODE_W-1:0]      to_node;
    logic [23:0]            edge_weight;
  } spd_in_t;

  typedef struct packed {
    logic [DIST_W-1:0]      best_distance;
    logic [NODE_W-1:0]      node_out;
    logic                   reachable;
  } spd_out_t;

  // node record: distance, done, pred, source mark, target mark
  typedef struct packed {
    logic [DIST_W-1:0]      distance;
    logic                   done;
    logic [NODE_W-1:0]      pred;
    logic                   src;
    logic                   tgt;
  } spd_node_t;

  localparam int NODE_REC_W = $bits(spd_node_t);

endpackage

// File: hw/rtl/spd_ram.sv
module spd_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/shortest_path_dijkstra_core.sv
// Channel | Dir | Handshake          | Payload
// in      | in  | in_valid/in_ready  | spd_in_t  (operation, nodes, weight)
// out     | out | out_valid/out_ready| spd_out_t (distance, node, reachable)
//
// Steps: add edge, mark and unknown items pass through accept, read and write
// back. A read predecessor puts its result out from the read state after
// accept, and input holds until that beat leaves. A run sets up every node
// record, then for each node it settles scans the nodes, marks the chosen one
// done and walks its edges; a final empty scan ends the search and a last
// scan picks the best target.
// After reset a clearing pass writes every node record and list head with
// in_ready low. Input stalls while a result waits in the output register.
module shortest_path_dijkstra_core
  import spd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  spd_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output spd_out_t out_data
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_OPRD  = 4'd2;
  localparam logic [3:0] S_OPWR  = 4'd3;
  localparam logic [3:0] S_INIT  = 4'd4;
  localparam logic [3:0] S_SCAN  = 4'd5;
  localparam logic [3:0] S_PICK  = 4'd6;
  localparam logic [3:0] S_EHEAD = 4'd7;
  localparam logic [3:0] S_EREQ  = 4'd8;
  localparam logic [3:0] S_ENODE = 4'd9;
  localparam logic [3:0] S_EUPD  = 4'd10;
  localparam logic [3:0] S_BEST  = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0] state;

  // node RAM
  logic                  n_we;
  logic [NODE_W-1:0]     n_waddr, n_raddr;
  spd_node_t             n_wdata, n_rdata;
  // list head RAM
  logic                  h_we;
  logic [NODE_W-1:0]     h_waddr, h_raddr;
  logic [EDGE_W-1:0]     h_wdata, h_rdata;
  // edge RAM
  logic                  e_we;
  logic [EDGE_W-1:0]     e_waddr, e_raddr;
  logic [EDGE_REC_W-1:0] e_wdata, e_rdata;

  spd_ram #(.DEPTH(NODES), .WIDTH(NODE_REC_W)) u_node (
    .clk, .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(n_raddr), .rdata(n_rdata));
  spd_ram #(.DEPTH(NODES), .WIDTH(EDGE_W)) u_head (
    .clk, .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata));
  spd_ram #(.DEPTH(EDGES), .WIDTH(EDGE_REC_W)) u_edge (
    .clk, .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata));

  spd_in_t           item;
  logic [EDGE_W-1:0] edge_count;
  logic [NODE_W:0]   idx;          // scan counter, can hold NODES
  logic [NODE_W-1:0] best, best_n;
  logic [DIST_W-1:0] bd, best_d;
  logic              found;
  logic [EDGE_W-1:0] cur_e;
  logic [NODE_W-1:0] e_dst;
  logic [WEIGHT_BITS-1:0] e_cost;
  logic [EDGE_W-1:0] e_nxt;
  logic [DIST_W-1:0] nd;
  logic [DIST_W:0]   sum;

  logic u_ok, v_ok;
  assign u_ok = (item.from_node != '0);
  assign v_ok = (item.to_node != '0);

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign {e_nxt, e_dst, e_cost} = e_rdata;
  assign sum = {1'b0, bd} + {{(DIST_W+1-WEIGHT_BITS){1'b0}}, e_cost};
  assign nd  = sum[DIST_W] ? DIST_INF : sum[DIST_W-1:0];

  // address and write-port steering
  always_comb begin
    n_we = 1'b0; n_waddr = idx[NODE_W-1:0]; n_wdata = n_rdata;
    n_raddr = idx[NODE_W-1:0];
    h_we = 1'b0; h_waddr = item.from_node; h_wdata = edge_count + EDGE_W'(1);
    h_raddr = item.from_node;
    e_we = 1'b0; e_waddr = edge_count + EDGE_W'(1);
    e_wdata = {h_rdata, item.to_node, item.edge_weight[WEIGHT_BITS-1:0]};
    e_raddr = cur_e;
    unique case (state)
      S_CLR: begin
        n_we = 1'b1; n_wdata = '0;
        // empty every adjacency list
        h_we = 1'b1; h_waddr = idx[NODE_W-1:0]; h_wdata = '0;
      end
      S_IDLE: begin
        n_raddr = in_data.from_node; h_raddr = in_data.from_node;
      end
      S_OPRD: begin
        n_raddr = item.from_node;
      end
      S_OPWR: begin
        n_waddr = item.from_node;
        if (item.operation == OP_SRC && u_ok) begin
          n_we = 1'b1; n_wdata.src = 1'b1;
        end else if (item.operation == OP_TGT && u_ok) begin
          n_we = 1'b1; n_wdata.tgt = 1'b1;
        end else if (item.operation == OP_ADD && u_ok && v_ok &&
                     edge_count != EDGE_W'(EDGES - 1)) begin
          h_we = 1'b1; e_we = 1'b1;
        end
      end
      S_INIT: begin
        // read at idx, write back in the next cycle at idx-1
        n_waddr = NODE_W'(idx - (NODE_W+1)'(1));
        n_we = (idx != '0);
        n_wdata.distance = n_rdata.src ? '0 : DIST_INF;
        n_wdata.done = 1'b0;
        n_wdata.pred = '0;
      end
      S_SCAN: ;
      S_PICK: begin
        n_waddr = best; n_raddr = best; h_raddr = best;
      end
      S_EHEAD: begin
        // mark the chosen node visited; its record was read on the pick cycle
        n_waddr = best;
        n_we = 1'b1; n_wdata.done = 1'b1;
      end
      S_EREQ: ;
      S_ENODE: begin
        n_raddr = e_dst;
      end
      S_EUPD: begin
        n_waddr = e_dst; n_raddr = e_dst;
        if (nd < n_rdata.distance) begin
          n_we = 1'b1; n_wdata.distance = nd; n_wdata.pred = best;
        end
      end
      S_BEST: begin
        // clear the marks as the final scan goes by
        n_waddr = NODE_W'(idx - (NODE_W+1)'(1));
        n_we = (idx != '0);
        n_wdata.src = 1'b0; n_wdata.tgt = 1'b0;
      end
      S_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR; idx <= '0; edge_count <= '0; out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_CLR: begin
          idx <= idx + (NODE_W+1)'(1);
          if (idx == (NODE_W+1)'(NODES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            item <= in_data;
            if (in_data.operation == OP_RUN) begin
              idx <= '0; state <= S_INIT;
            end else state <= S_OPRD;
          end
        end
        S_OPRD: begin
          // node and head data are out of the RAMs now
          if (item.operation == OP_READ) begin
            out_data.best_distance <= '0;
            out_data.reachable <= 1'b0;
            out_data.node_out <= u_ok ? n_rdata.pred : '0;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end else state <= S_OPWR;
        end
        S_OPWR: begin
          if (h_we) edge_count <= edge_count + EDGE_W'(1);
          state <= S_IDLE;
        end
        S_INIT: begin
          if (idx == (NODE_W+1)'(NODES)) begin
            idx <= '0; bd <= DIST_INF; found <= 1'b0; best <= '0;
            state <= S_SCAN;
          end else idx <= idx + (NODE_W+1)'(1);
        end
        S_SCAN: begin
          // n_rdata belongs to idx-1; node 0 skipped
          idx <= idx + (NODE_W+1)'(1);
          if (idx > (NODE_W+1)'(1) && !n_rdata.done && n_rdata.distance < bd) begin
            bd <= n_rdata.distance; best <= NODE_W'(idx - (NODE_W+1)'(1));
            found <= 1'b1;
          end
          if (idx == (NODE_W+1)'(NODES)) state <= S_PICK;
        end
        S_PICK: begin
          if (found) state <= S_EHEAD;
          else begin
            idx <= '0; best_d <= DIST_INF; best_n <= '0; state <= S_BEST;
          end
        end
        S_EHEAD: begin
          cur_e <= h_rdata;
          state <= (h_rdata == '0) ? S_SCAN : S_EREQ;
          if (h_rdata == '0) begin
            idx <= '0; bd <= DIST_INF; found <= 1'b0;
          end
        end
        S_EREQ: state <= S_ENODE;
        S_ENODE: state <= S_EUPD;
        S_EUPD: begin
          cur_e <= e_nxt;
          if (e_nxt == '0) begin
            idx <= '0; bd <= DIST_INF; found <= 1'b0; state <= S_SCAN;
          end else state <= S_EREQ;
        end
        S_BEST: begin
          idx <= idx + (NODE_W+1)'(1);
          if (idx > (NODE_W+1)'(1) && n_rdata.tgt && n_rdata.distance < best_d) begin
            best_d <= n_rdata.distance; best_n <= NODE_W'(idx - (NODE_W+1)'(1));
          end
          if (idx == (NODE_W+1)'(NODES)) state <= S_OUT;
        end
        S_OUT: begin
          out_data.best_distance <= best_d;
          out_data.node_out <= best_n;
          out_data.reachable <= (best_d != DIST_INF);
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (state == S_IDLE)) else $error("accept while busy");
  a_unreach: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.reachable) |-> (out_data.node_out != '0))
    else $error("reachable without node");
  a_edge_cap: assert property (@(posedge clk) disable iff (rst)
    edge_count <= EDGE_W'(EDGES - 1)) else $error("edge count overflow");

endmodule
